// ----- src/scs_pkg.sv -----
// ----------------------------------------------------------------------------
// scs_pkg: shared constants and types for the set crossover splitter
// Node widths, result limit, queue depth and the queue status bundle.
// ----------------------------------------------------------------------------
package scs_pkg;

  // default node space and fixed field widths
  localparam int NODE_COUNT_DEF = 64;
  localparam int NODE_W         = 6;
  localparam int MAX_RESULTS    = 64;
  localparam int RES_W          = $clog2(MAX_RESULTS + 1);

  // runs that can wait between front and back
  localparam int Q_DEPTH        = 2;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } scs_qstat_t;

endpackage

// ----- src/scs_front.sv -----
// ----------------------------------------------------------------------------
// scs_front: parent list loader
// Marks each parent's node in its bitmap, one pair per word, and hands both
// bitmaps to the run queue on the final pair, clearing them for the next run.
// ----------------------------------------------------------------------------
module scs_front
  import scs_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [NODE_W-1:0]     first_parent_node,
  input  logic [NODE_W-1:0]     second_parent_node,
  input  logic                  final_pair,
  input  scs_qstat_t            qstat,
  output logic                  push,
  output logic [NODE_COUNT-1:0] push_first,
  output logic [NODE_COUNT-1:0] push_second
);

  localparam int IW = $clog2(NODE_COUNT);

  logic [NODE_COUNT-1:0] first_marks, first_marks_next;
  logic [NODE_COUNT-1:0] second_marks, second_marks_next;
  logic                  accept;

  // node decode, indexes outside the node space mark nothing
  function automatic logic [NODE_COUNT-1:0] mark_bit(input logic [NODE_W-1:0] node);
    logic [NODE_COUNT-1:0] one;
    one = {{(NODE_COUNT-1){1'b0}}, 1'b1};
    if ({1'b0, node} < (NODE_W+1)'(NODE_COUNT)) begin
      return one << node[IW-1:0];
    end else begin
      return '0;
    end
  endfunction

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  // merged bitmaps including the current pair
  always_comb begin
    first_marks_next  = first_marks  | mark_bit(first_parent_node);
    second_marks_next = second_marks | mark_bit(second_parent_node);
  end

  // hand off on the final pair
  assign push        = accept && final_pair;
  assign push_first  = first_marks_next;
  assign push_second = second_marks_next;

  // mark registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_marks  <= '0;
      second_marks <= '0;
    end else if (accept) begin
      if (final_pair) begin
        first_marks  <= '0;
        second_marks <= '0;
      end else begin
        first_marks  <= first_marks_next;
        second_marks <= second_marks_next;
      end
    end
  end

endmodule

// ----- src/scs_queue.sv -----
// ----------------------------------------------------------------------------
// scs_queue: run queue
// Small FIFO of finished parent bitmap pairs between loader and splitter.
// ----------------------------------------------------------------------------
module scs_queue
  import scs_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [NODE_COUNT-1:0] push_first,
  input  logic [NODE_COUNT-1:0] push_second,
  input  logic                  pop,
  output logic [NODE_COUNT-1:0] head_first,
  output logic [NODE_COUNT-1:0] head_second,
  output scs_qstat_t            qstat
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  logic [2*NODE_COUNT-1:0] entries [Q_DEPTH];
  logic [PW-1:0]           wr_ptr;
  logic [PW-1:0]           rd_ptr;
  logic [CW-1:0]           fill;

  assign qstat.full  = (fill == CW'(Q_DEPTH));
  assign qstat.empty = (fill == '0);
  assign {head_first, head_second} = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= {push_first, push_second};
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(Q_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(Q_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- src/scs_back.sv -----
// ----------------------------------------------------------------------------
// scs_back: child splitter and emitter
// Scans one node per cycle in ascending order to build both child bitmaps,
// then walks each child from the top node down, emitting one word per node.
// ----------------------------------------------------------------------------
module scs_back
  import scs_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  scs_qstat_t            qstat,
  input  logic [NODE_COUNT-1:0] head_first,
  input  logic [NODE_COUNT-1:0] head_second,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  which_child,
  output logic [NODE_W-1:0]     child_node,
  output logic                  run_end
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(NODE_COUNT + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_EMIT1 = 2'd2;
  localparam logic [1:0] ST_EMIT2 = 2'd3;

  logic [1:0]            state;
  logic [NODE_COUNT-1:0] first_sh, second_sh;
  logic [NODE_COUNT-1:0] child1, child2;
  logic [IW-1:0]         idx;
  logic [CW-1:0]         n1, n2, n1_next, n2_next;
  logic [RES_W-1:0]      emitted, total;
  logic [CW:0]           sum_next;
  logic                  to1, to2, a, b, shared, single;
  logic                  slot_free, cur_bit, last_word, idx_end, emit_word;

  // per-node assignment during the scan
  always_comb begin
    a       = first_sh[0];
    b       = second_sh[0];
    shared  = a && b;
    single  = a ^ b;
    to1     = shared || (single && (n1 < n2));
    to2     = shared || (single && !(n1 < n2));
    n1_next = n1 + CW'(to1);
    n2_next = n2 + CW'(to2);
    sum_next = {1'b0, n1_next} + {1'b0, n2_next};
  end

  // emission helpers
  assign slot_free = !out_valid || out_ready;
  assign cur_bit   = (state == ST_EMIT2) ? child2[NODE_COUNT-1] : child1[NODE_COUNT-1];
  assign last_word = cur_bit && ((emitted + 1'b1) == total);
  assign idx_end   = (idx == IW'(NODE_COUNT-1));
  assign pop       = (state == ST_IDLE) && !qstat.empty;
  assign emit_word = ((state == ST_EMIT1) || (state == ST_EMIT2)) && cur_bit && slot_free;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // output valid: set on a new word, cleared once taken
      if (emit_word) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            first_sh  <= head_first;
            second_sh <= head_second;
            idx       <= '0;
            n1        <= '0;
            n2        <= '0;
            emitted   <= '0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          first_sh  <= first_sh >> 1;
          second_sh <= second_sh >> 1;
          child1    <= {to1, child1[NODE_COUNT-1:1]};
          child2    <= {to2, child2[NODE_COUNT-1:1]};
          n1        <= n1_next;
          n2        <= n2_next;
          if (idx_end) begin
            idx <= IW'(NODE_COUNT-1);
            if (sum_next > (CW+1)'(MAX_RESULTS)) begin
              total <= RES_W'(MAX_RESULTS);
            end else begin
              total <= RES_W'(sum_next);
            end
            state <= (sum_next == '0) ? ST_IDLE : ST_EMIT1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_EMIT1, ST_EMIT2: begin
          if (!cur_bit || slot_free) begin
            if (cur_bit) begin
              which_child <= (state == ST_EMIT2);
              child_node  <= NODE_W'(idx);
              run_end     <= last_word;
              emitted     <= emitted + 1'b1;
            end
            if (state == ST_EMIT2) begin
              child2 <= child2 << 1;
            end else begin
              child1 <= child1 << 1;
            end
            if (idx == '0) begin
              idx <= IW'(NODE_COUNT-1);
            end else begin
              idx <= idx - 1'b1;
            end
            if (last_word) begin
              state <= ST_IDLE;
            end else if (idx == '0) begin
              state <= (state == ST_EMIT1) ? ST_EMIT2 : ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // the balancing rule keeps child two at most one node ahead
  a_balance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ((n2 == n1) || (n2 == n1 + 1'b1)))
    else $error("child counts out of balance");

  // never emit more than the run's total
  a_count: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EMIT1) || (state == ST_EMIT2)) |-> (emitted < total))
    else $error("emission count past total");

  // a waiting run is taken up at once
  a_start: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_IDLE) && !qstat.empty) |=> (state == ST_SCAN))
    else $error("queued run not started");

  // new words come only from the emit walk
  a_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (($past(state) == ST_EMIT1) || ($past(state) == ST_EMIT2)))
    else $error("output word outside emission");
`endif

endmodule

// ----- src/set_crossover_splitter.sv -----
// ----------------------------------------------------------------------------
// set_crossover_splitter: crossover of two parent node sets into two children
// Loads parent node pairs into bitmaps, then splits and emits child nodes.
// ----------------------------------------------------------------------------
//  channel | signals                                          | accepted when
//  in      | first_parent_node, second_parent_node, final_pair | in_valid & in_ready
//  out     | which_child, child_node, run_end                  | out_valid & out_ready
//
//  Pairs load one per cycle while the run queue has room (two runs deep).
//  Per run the splitter fetches the queue head, scans one node per cycle, then
//  walks both children, holding while the output is stalled; the walk is
//  skipped for a run with no child nodes and ends early on the last word.
//  Reset clears marks, queue pointers, sequencer and output valid.
//  Output stalls back up into the queue and then to in_ready only.
// ----------------------------------------------------------------------------
module set_crossover_splitter
  import scs_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NODE_W-1:0] first_parent_node,
  input  logic [NODE_W-1:0] second_parent_node,
  input  logic              final_pair,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              which_child,
  output logic [NODE_W-1:0] child_node,
  output logic              run_end
);

  scs_qstat_t            qstat;
  logic                  push, pop;
  logic [NODE_COUNT-1:0] push_first, push_second;
  logic [NODE_COUNT-1:0] head_first, head_second;

  // loader
  scs_front #(.NODE_COUNT(NODE_COUNT)) u_front (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .first_parent_node  (first_parent_node),
    .second_parent_node (second_parent_node),
    .final_pair         (final_pair),
    .qstat              (qstat),
    .push               (push),
    .push_first         (push_first),
    .push_second        (push_second)
  );

  // run queue
  scs_queue #(.NODE_COUNT(NODE_COUNT)) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_first  (push_first),
    .push_second (push_second),
    .pop         (pop),
    .head_first  (head_first),
    .head_second (head_second),
    .qstat       (qstat)
  );

  // splitter and emitter
  scs_back #(.NODE_COUNT(NODE_COUNT)) u_back (
    .clk         (clk),
    .rst         (rst),
    .qstat       (qstat),
    .head_first  (head_first),
    .head_second (head_second),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .which_child (which_child),
    .child_node  (child_node),
    .run_end     (run_end)
  );

endmodule
